// ===== rtl/lpht_pkg.sv =====
package lpht_pkg;

	localparam int INDEX_BITS = 12;
	localparam int VALUE_BITS = 32;
	localparam int KEY_BITS   = 64;
	localparam int GEN_BITS   = 8;
	localparam int HASH_SHIFT = 33;
	localparam int COUNT_BITS = INDEX_BITS + 1;
	localparam int SALT_BITS  = 64;

	localparam logic [SALT_BITS-1:0] SALT_RESET = 64'd11400714819323198485;

	localparam logic [2:0] KIND_SET    = 3'd0;
	localparam logic [2:0] KIND_ADD    = 3'd1;
	localparam logic [2:0] KIND_LOOKUP = 3'd2;
	localparam logic [2:0] KIND_ERASE  = 3'd3;
	localparam logic [2:0] KIND_CLEAR  = 3'd4;

	typedef logic [INDEX_BITS-1:0] index_t;
	typedef logic [GEN_BITS-1:0]   gen_t;

	// one table slot as stored in memory
	typedef struct packed {
		gen_t                  gen;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} slot_t;

	localparam int SLOT_BITS = $bits(slot_t);

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_MISC
	} state_t;

endpackage

// ===== rtl/linear_probe_hash_table.sv =====
// channel  | handshake           | payload
// ---------+---------------------+------------------------------------
// input    | in_valid / in_ready | kind, key, value
// output   | out_valid/out_ready | value_out, found, count, status
// config   | cfg_wr_en           | cfg_wr_data (salt)
//
// set/add/lookup/erase hash the key, then probe P slots (1 to 4096), one
// slot read per cycle while the output is free, from the slot memory with
// one write and one read port. A clear that wraps the generation adds a
// sweep over all 4096 slots; after reset the same sweep runs with in_ready
// low. A result not taken holds the block before its write.
module linear_probe_hash_table
	import lpht_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [SALT_BITS-1:0]  cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            kind,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [VALUE_BITS-1:0] value_out,
	output logic                  found,
	output logic [COUNT_BITS-1:0] count,
	output logic                  status
);

	state_t state_q, state_d;
	logic [SALT_BITS-1:0]  salt_q;
	logic [2:0]            kind_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	index_t                hx_q;
	index_t                idx_q, idx_d;
	index_t                n_q, n_d;
	index_t                sweep_q, sweep_d;
	gen_t                  gen_q, gen_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;

	logic                  ov_q, ov_d;
	logic [VALUE_BITS-1:0] vout_q, vout_d;
	logic                  found_q, found_d;
	logic                  status_q, status_d;

	logic                  wr_en, rd_en;
	index_t                wr_addr, rd_addr;
	slot_t                 wr_data, rd_data;
	logic [SLOT_BITS-1:0]  rd_raw;

	logic                  out_free, accept, hit, live, full;
	logic [2*INDEX_BITS-1:0] prod;
	index_t                home;
	logic [VALUE_BITS-1:0] new_val;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !ov_q || out_ready;

	assign out_valid = ov_q;
	assign value_out = vout_q;
	assign found     = found_q;
	assign count     = cnt_q;
	assign status    = status_q;

	// home slot: low bits of the product need only low bits of both factors
	assign prod = hx_q * {salt_q[INDEX_BITS-1:1], 1'b1};
	assign home = prod[INDEX_BITS-1:0];

	// probe check on the slot just read
	assign rd_data = slot_t'(rd_raw);
	assign live    = (rd_data.gen == gen_q);
	assign hit     = !live || (rd_data.key == key_q);
	assign full    = !hit && (n_q == '1);
	assign new_val = (kind_q == KIND_ADD) ? rd_data.value + val_q : val_q;

	lpht_ram #(
		.ADDR_BITS(INDEX_BITS),
		.DATA_BITS(SLOT_BITS)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	// next state, memory access and result
	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		n_d      = n_q;
		sweep_d  = sweep_q;
		gen_d    = gen_q;
		cnt_d    = cnt_q;
		ov_d     = ov_q && !out_ready;
		vout_d   = vout_q;
		found_d  = found_q;
		status_d = status_q;
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_data  = '0;
		rd_en    = 1'b0;
		rd_addr  = idx_q;
		case (state_q)
			ST_SWEEP: begin
				wr_en   = 1'b1;
				wr_addr = sweep_q;
				sweep_d = sweep_q + 1'b1;
				if (sweep_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = (kind <= KIND_ERASE) ? ST_HASH : ST_MISC;
				end
			end
			ST_HASH: begin
				rd_en   = 1'b1;
				rd_addr = home;
				idx_d   = home;
				n_d     = '0;
				state_d = ST_PROBE;
			end
			ST_PROBE: begin
				if (out_free) begin
					if (hit || full) begin
						ov_d     = 1'b1;
						found_d  = hit && live;
						status_d = 1'b0;
						vout_d   = '0;
						state_d  = ST_IDLE;
						case (kind_q)
							KIND_SET, KIND_ADD: begin
								if (full) begin
									status_d = 1'b1;
								end else if (live) begin
									wr_en   = 1'b1;
									wr_data = '{gen: gen_q, key: key_q, value: new_val};
									vout_d  = new_val;
								end else begin
									wr_en   = 1'b1;
									wr_data = '{gen: gen_q, key: key_q, value: val_q};
									vout_d  = val_q;
									cnt_d   = cnt_q + 1'b1;
								end
							end
							KIND_LOOKUP: begin
								if (hit && live) begin
									vout_d = rd_data.value;
								end
							end
							default: begin
								if (hit && live) begin
									wr_en = 1'b1;
									if (cnt_q != '0) begin
										cnt_d = cnt_q - 1'b1;
									end
								end
							end
						endcase
					end else begin
						idx_d   = idx_q + 1'b1;
						n_d     = n_q + 1'b1;
						rd_en   = 1'b1;
						rd_addr = idx_q + 1'b1;
					end
				end
			end
			ST_MISC: begin
				if (out_free) begin
					ov_d     = 1'b1;
					vout_d   = '0;
					found_d  = 1'b0;
					status_d = 1'b0;
					state_d  = ST_IDLE;
					if (kind_q == KIND_CLEAR) begin
						cnt_d = '0;
						gen_d = gen_q + 1'b1;
						if (gen_d == '0) begin
							gen_d   = gen_t'(1);
							sweep_d = '0;
							state_d = ST_SWEEP;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			sweep_q <= '0;
			gen_q   <= gen_t'(1);
			cnt_q   <= '0;
			ov_q    <= 1'b0;
			salt_q  <= SALT_RESET;
		end else begin
			state_q <= state_d;
			sweep_q <= sweep_d;
			gen_q   <= gen_d;
			cnt_q   <= cnt_d;
			ov_q    <= ov_d;
			if (cfg_wr_en) begin
				salt_q <= cfg_wr_data;
			end
		end
	end

	// transaction payload and probe position
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			key_q  <= key;
			val_q  <= value;
			hx_q   <= key[INDEX_BITS-1:0] ^ key[HASH_SHIFT +: INDEX_BITS];
		end
		idx_q    <= idx_d;
		n_q      <= n_d;
		vout_q   <= vout_d;
		found_q  <= found_d;
		status_q <= status_d;
	end

endmodule

// ===== rtl/lpht_ram.sv =====
module lpht_ram #(
	parameter int ADDR_BITS = 12,
	parameter int DATA_BITS = 104
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [DATA_BITS-1:0] wr_data,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic [DATA_BITS-1:0] rd_data
);

	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== tb/sv/linear_probe_hash_table_checker.sv =====
module linear_probe_hash_table_checker
	import lpht_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [SALT_BITS-1:0]  cfg_wr_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [2:0]            kind,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [VALUE_BITS-1:0] value_out,
	input  logic                  found,
	input  logic [COUNT_BITS-1:0] count,
	input  logic                  status,
	output int                    fail_count,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_SLOTS = 1 << INDEX_BITS;

	typedef struct {
		logic [VALUE_BITS-1:0] value_out;
		logic                  found;
		logic [COUNT_BITS-1:0] count;
		logic                  status;
	} answer_t;

	// shadow copy of the table
	logic [KEY_BITS-1:0]   shadow_key   [TABLE_SLOTS];
	logic [VALUE_BITS-1:0] shadow_value [TABLE_SLOTS];
	gen_t                  shadow_gen   [TABLE_SLOTS];
	gen_t                  live_gen;
	logic [COUNT_BITS-1:0] live_count;
	logic [SALT_BITS-1:0]  hash_salt;
	answer_t               answers_due[$];

	initial begin
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			shadow_gen[i] = '0;
			shadow_key[i] = '0;
			shadow_value[i] = '0;
		end
		live_gen = 1;
		live_count = '0;
		hash_salt = SALT_RESET;
		fail_count = 0;
		pending = 0;
	end

	// work out the answer to one transaction and update the shadow table
	task automatic apply_op(input logic [2:0] op, input logic [KEY_BITS-1:0] k,
			input logic [VALUE_BITS-1:0] v);
		answer_t a;
		logic [63:0] h;
		index_t idx;
		index_t pos;
		bit have;
		bit live;
		a.value_out = '0;
		a.found = 1'b0;
		a.status = 1'b0;
		have = 1'b0;
		live = 1'b0;
		pos = '0;
		if (op <= KIND_ERASE) begin
			h = (k ^ (k >> HASH_SHIFT)) * (hash_salt | 64'd1);
			idx = h[INDEX_BITS-1:0];
			for (int n = 0; n < TABLE_SLOTS; n++) begin
				if (shadow_gen[idx] != live_gen || shadow_key[idx] == k) begin
					have = 1'b1;
					pos = idx;
					break;
				end
				idx = idx + 1'b1;
			end
			if (have)
				live = (shadow_gen[pos] == live_gen);
			a.found = live;
			if (op == KIND_SET || op == KIND_ADD) begin
				if (!have) begin
					a.status = 1'b1;
				end else if (live) begin
					if (op == KIND_SET)
						shadow_value[pos] = v;
					else
						shadow_value[pos] = shadow_value[pos] + v;
					a.value_out = shadow_value[pos];
				end else begin
					shadow_key[pos] = k;
					shadow_value[pos] = v;
					shadow_gen[pos] = live_gen;
					live_count = live_count + 1'b1;
					a.value_out = v;
				end
			end else if (op == KIND_LOOKUP) begin
				if (live)
					a.value_out = shadow_value[pos];
			end else if (live) begin
				shadow_key[pos] = '0;
				shadow_value[pos] = '0;
				shadow_gen[pos] = '0;
				if (live_count != 0)
					live_count = live_count - 1'b1;
			end
		end else if (op == KIND_CLEAR) begin
			live_count = '0;
			live_gen = live_gen + 1'b1;
			if (live_gen == 0) begin
				for (int i = 0; i < TABLE_SLOTS; i++)
					shadow_gen[i] = '0;
				live_gen = 1;
			end
		end
		a.count = live_count;
		answers_due.push_back(a);
	endtask

	// compare results first, then predict the newly accepted transaction
	always @(posedge clk) begin
		answer_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					$display("%0t: result with nothing expected: value_out %h found %b count %0d status %b",
						$realtime, value_out, found, count, status);
					fail_count++;
				end else begin
					e = answers_due.pop_front();
					if (value_out !== e.value_out) begin
						$display("%0t: value_out expected %h actual %h", $realtime, e.value_out, value_out);
						fail_count++;
					end
					if (found !== e.found) begin
						$display("%0t: found expected %b actual %b", $realtime, e.found, found);
						fail_count++;
					end
					if (count !== e.count) begin
						$display("%0t: count expected %0d actual %0d", $realtime, e.count, count);
						fail_count++;
					end
					if (status !== e.status) begin
						$display("%0t: status expected %b actual %b", $realtime, e.status, status);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				apply_op(kind, key, value);
			if (cfg_wr_en)
				hash_salt = cfg_wr_data;
			pending = answers_due.size();
		end
	end

endmodule

// ===== tb/sv/linear_probe_hash_table_tb.sv =====
module linear_probe_hash_table_tb;
	import lpht_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [SALT_BITS-1:0]  cfg_wr_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [2:0]            kind;
	logic [KEY_BITS-1:0]   key;
	logic [VALUE_BITS-1:0] value;
	logic                  out_valid;
	logic                  out_ready;
	logic [VALUE_BITS-1:0] value_out;
	logic                  found;
	logic [COUNT_BITS-1:0] count;
	logic                  status;
	int                    fail_count;
	int                    pending;
	int                    cycles;
	int                    burst_left;
	logic [KEY_BITS-1:0]   key_pool[24];

	linear_probe_hash_table dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind), .key(key), .value(value),
		.out_valid(out_valid), .out_ready(out_ready), .value_out(value_out),
		.found(found), .count(count), .status(status)
	);

	linear_probe_hash_table_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind), .key(key), .value(value),
		.out_valid(out_valid), .out_ready(out_ready), .value_out(value_out),
		.found(found), .count(count), .status(status),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver stall pattern: four modes in turn, chosen from the cycle counter
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			case ((cycles / 64) % 4)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 0);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ((cycles % 7) < 4);
			endcase
		end
	end

	// one input transaction, sent in bursts with gaps
	task automatic send(input logic [2:0] op, input logic [KEY_BITS-1:0] k,
			input logic [VALUE_BITS-1:0] v);
		in_valid <= 1'b1;
		kind <= op;
		key <= k;
		value <= v;
		do @(posedge clk); while (!in_ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 12);
		end
	endtask

	// salt write once every result is back
	task automatic write_salt(input logic [SALT_BITS-1:0] s);
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= s;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// mostly well-formed traffic on a small key pool, some noise
	task automatic random_phase(input int n_items, input bit clustered);
		int r;
		logic [KEY_BITS-1:0] k;
		for (int i = 0; i < 24; i++) begin
			key_pool[i] = rand64();
			if (clustered)
				key_pool[i][44:5] = '0;
		end
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			k = key_pool[$urandom_range(0, 23)];
			if (r < 25)
				send(KIND_SET, k, $urandom());
			else if (r < 45)
				send(KIND_ADD, k, $urandom());
			else if (r < 70)
				send(KIND_LOOKUP, k, $urandom());
			else if (r < 85)
				send(KIND_ERASE, k, $urandom());
			else if (r < 88)
				send(KIND_CLEAR, rand64(), $urandom());
			else if (r < 91)
				send(3'($urandom_range(5, 7)), rand64(), $urandom());
			else
				send(3'($urandom_range(0, 3)), rand64(), $urandom());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		kind = '0;
		key = '0;
		value = '0;
		burst_left = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes and each operation
		write_salt(SALT_RESET);
		send(KIND_SET, '0, '0);
		send(KIND_SET, '1, '1);
		send(KIND_LOOKUP, '0, '1);
		send(KIND_LOOKUP, '1, '0);
		send(KIND_ADD, '1, 32'd1);
		send(KIND_ADD, 64'h1234_5678_9abc_def0, 32'h8000_0000);
		send(KIND_LOOKUP, 64'h5555_5555_5555_5555, '0);
		send(KIND_ERASE, '1, '0);
		send(KIND_ERASE, '1, '0);
		send(KIND_LOOKUP, '1, '0);
		send(KIND_CLEAR, '0, '0);
		send(KIND_LOOKUP, '0, '0);
		send(3'd5, '1, '1);
		send(3'd6, '0, '0);
		send(3'd7, '1, '1);

		// erase in a cluster hides the later entry of that cluster
		write_salt('0);
		send(KIND_SET, 64'd5, 32'd11);
		send(KIND_SET, (64'd1 << 33) | 64'd4, 32'd22);
		send(KIND_ERASE, 64'd5, '0);
		send(KIND_LOOKUP, (64'd1 << 33) | 64'd4, '0);
		send(KIND_ADD, (64'd1 << 33) | 64'd4, 32'd1);

		// random phases over several salts
		write_salt('1);
		random_phase(50, 1'b0);
		write_salt('0);
		random_phase(50, 1'b1);
		write_salt(rand64());
		random_phase(50, 1'b0);

		// enough clears to wrap the generation, then stale slots must stay dead
		write_salt(64'd1);
		random_phase(20, 1'b1);
		for (int i = 0; i < 260; i++)
			send(KIND_CLEAR, rand64(), $urandom());
		random_phase(30, 1'b1);
		write_salt(SALT_RESET);
		random_phase(30, 1'b0);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/linear_probe_hash_table.sv
tb/sv/linear_probe_hash_table_checker.sv
tb/sv/linear_probe_hash_table_tb.sv
